### rtl/core/ttup_pkg.sv
// Shared types and constants for the text-to-unsigned parser.
// No dependencies; every other file of the block refers to it by scoped names.
package ttup_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int BASE_WIDTH          = 6;
   localparam int COUNT_WIDTH         = 16;
   localparam int MID_DEPTH           = 4;
   localparam int MID_AW              = $clog2(MID_DEPTH);
   localparam int RSP_DEPTH           = 2;
   localparam int RSP_AW              = $clog2(RSP_DEPTH);

   localparam logic [BASE_WIDTH-1:0]  BASE_RESET = 6'd10;
   localparam logic [BASE_WIDTH-1:0]  BASE_MAX   = 6'd36;
   localparam logic [BASE_WIDTH-1:0]  BASE_HEX   = 6'd16;
   localparam logic [BASE_WIDTH-1:0]  BASE_DEC   = 6'd10;
   localparam logic [BASE_WIDTH-1:0]  BASE_AUTO  = 6'd0;
   localparam logic [BASE_WIDTH-1:0]  NOT_DIGIT  = 6'h3F;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = 16'hFFFF;

   typedef struct packed {
      logic [7:0] char_code;
      logic       first_char;
   } ttup_req_type;

   typedef struct packed {
      logic [63:0]            parsed_value;
      logic [COUNT_WIDTH-1:0] end_offset;
   } ttup_rsp_type;

   typedef struct packed {
      logic                  first_char;
      logic [BASE_WIDTH-1:0] base;
      logic [BASE_WIDTH-1:0] digit;
      logic                  is_space;
      logic                  is_x;
   } ttup_item_type;

   typedef struct packed {
      logic         push;
      ttup_rsp_type data;
   } ttup_emit_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_LEAD   = 5'b00010,
      PH_AUTO   = 5'b00100,
      PH_HEX    = 5'b01000,
      PH_DIGITS = 5'b10000
   } ttup_phase_type;

   function automatic logic [COUNT_WIDTH-1:0] count_add(input logic [COUNT_WIDTH-1:0] c,
                                                        input logic [1:0] n);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, c} + (COUNT_WIDTH+1)'(n);
      return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
   endfunction

endpackage

### rtl/core/ttup_front.sv
// Front end: base register, character classification and the item queue.
// Depends on ttup_pkg.
module ttup_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  ttup_pkg::ttup_req_type           req_data,
   input  logic                             csr_write_enable,
   input  logic [ttup_pkg::BASE_WIDTH-1:0]  csr_write_data,
   output logic                             mid_valid,
   output ttup_pkg::ttup_item_type          mid_item,
   input  logic                             mid_take
);

   logic [ttup_pkg::BASE_WIDTH-1:0] base_ff;
   ttup_pkg::ttup_item_type         slot_ff [ttup_pkg::MID_DEPTH];
   logic [ttup_pkg::MID_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ttup_pkg::MID_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ttup_pkg::MID_AW:0]       count_ff, count_in;
   ttup_pkg::ttup_item_type         item;
   logic                            accept;
   logic [7:0]                      c;

   assign c = req_data.char_code;

   always_comb begin
      item            = '0;
      item.first_char = req_data.first_char;
      item.base       = base_ff;
      item.is_space   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
      item.is_x       = (c == 8'h78);
      if (c >= 8'h30 && c <= 8'h39) begin
         item.digit = ttup_pkg::BASE_WIDTH'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         item.digit = ttup_pkg::BASE_WIDTH'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         item.digit = ttup_pkg::BASE_WIDTH'(c - 8'h41 + 8'd10);
      end else begin
         item.digit = ttup_pkg::NOT_DIGIT;
      end
   end

   assign req_full  = (count_ff == (ttup_pkg::MID_AW+1)'(ttup_pkg::MID_DEPTH));
   assign accept    = req_push && !req_full;
   assign mid_valid = (count_ff != '0);
   assign mid_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = mid_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (ttup_pkg::MID_AW+1)'(accept)
                           - (ttup_pkg::MID_AW+1)'(mid_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= ttup_pkg::BASE_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### rtl/core/ttup_back.sv
// Back end: parse state machine, multiply-accumulate and consumed-count tracking.
// Depends on ttup_pkg.
module ttup_back #(
   parameter int VALUE_WIDTH = ttup_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mid_valid,
   input  ttup_pkg::ttup_item_type mid_item,
   output logic                    mid_take,
   input  logic                    rsp_q_full,
   output ttup_pkg::ttup_emit_type emit
);

   ttup_pkg::ttup_phase_type            phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0]              acc_ff, acc_in;
   logic [ttup_pkg::BASE_WIDTH-1:0]     base_ff, base_in;
   logic [ttup_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                                pz_ff, pz_in;
   logic                                done;
   logic                                auto_mode;

   assign mid_take = mid_valid && !rsp_q_full;

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      count_in  = count_ff;
      pz_in     = pz_ff;
      emit      = '0;
      done      = 1'b0;
      auto_mode = 1'b0;
      if (mid_take) begin
         if (mid_item.first_char) begin
            acc_in   = '0;
            count_in = '0;
            pz_in    = 1'b0;
            base_in  = mid_item.base;
            if (mid_item.base > ttup_pkg::BASE_MAX) begin
               phase_in  = ttup_pkg::PH_IDLE;
               emit.push = 1'b1;
               done      = 1'b1;
            end else begin
               phase_in = ttup_pkg::PH_LEAD;
            end
         end
         if (!done && phase_in == ttup_pkg::PH_LEAD) begin
            if (mid_item.is_space) begin
               count_in = ttup_pkg::count_add(count_in, 2'd1);
               done     = 1'b1;
            end else begin
               pz_in = 1'b0;
               if (base_in == ttup_pkg::BASE_AUTO) begin
                  phase_in = ttup_pkg::PH_AUTO;
               end else if (base_in == ttup_pkg::BASE_HEX) begin
                  phase_in = ttup_pkg::PH_HEX;
               end else begin
                  phase_in = ttup_pkg::PH_DIGITS;
               end
            end
         end
         if (!done && (phase_in == ttup_pkg::PH_AUTO || phase_in == ttup_pkg::PH_HEX)) begin
            auto_mode = (phase_in == ttup_pkg::PH_AUTO);
            if (!pz_in) begin
               if (mid_item.digit == '0) begin
                  pz_in = 1'b1;
                  done  = 1'b1;
               end else begin
                  if (auto_mode) begin
                     base_in = ttup_pkg::BASE_DEC;
                  end
                  phase_in = ttup_pkg::PH_DIGITS;
               end
            end else begin
               pz_in = 1'b0;
               if (mid_item.is_x) begin
                  count_in = ttup_pkg::count_add(count_in, 2'd2);
                  done     = 1'b1;
                  if (auto_mode) begin
                     base_in  = ttup_pkg::BASE_HEX;
                     phase_in = ttup_pkg::PH_HEX;
                  end else begin
                     phase_in = ttup_pkg::PH_DIGITS;
                  end
               end else begin
                  if (auto_mode) begin
                     base_in = ttup_pkg::BASE_DEC;
                  end
                  count_in = ttup_pkg::count_add(count_in, 2'd1);
                  phase_in = ttup_pkg::PH_DIGITS;
               end
            end
         end
         if (!done && phase_in == ttup_pkg::PH_DIGITS) begin
            if (mid_item.digit < base_in) begin
               acc_in   = VALUE_WIDTH'(acc_in * VALUE_WIDTH'(base_in)
                                       + VALUE_WIDTH'(mid_item.digit));
               count_in = ttup_pkg::count_add(count_in, 2'd1);
            end else begin
               emit.push              = 1'b1;
               emit.data.parsed_value = 64'(acc_in);
               emit.data.end_offset   = count_in;
               phase_in               = ttup_pkg::PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ttup_pkg::PH_IDLE;
         acc_ff   <= '0;
         base_ff  <= '0;
         count_ff <= '0;
         pz_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         count_ff <= count_in;
         pz_ff    <= pz_in;
      end
   end

endmodule

### rtl/core/ttup_rsp_queue.sv
// Result queue between the back end and the rsp_ port.
// Depends on ttup_pkg.
module ttup_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  ttup_pkg::ttup_emit_type emit,
   output logic                    rsp_q_full,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output ttup_pkg::ttup_rsp_type  rsp_data
);

   ttup_pkg::ttup_rsp_type      slot_ff [ttup_pkg::RSP_DEPTH];
   logic [ttup_pkg::RSP_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ttup_pkg::RSP_AW:0]   count_ff, count_in;
   logic                        take;

   assign rsp_q_full = (count_ff == (ttup_pkg::RSP_AW+1)'(ttup_pkg::RSP_DEPTH));
   assign rsp_empty  = (count_ff == '0);
   assign rsp_data   = slot_ff[rd_ptr_ff];
   assign take       = rsp_pop && !rsp_empty;

   always_comb begin
      count_in = count_ff + (ttup_pkg::RSP_AW+1)'(emit.push)
                          - (ttup_pkg::RSP_AW+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (emit.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.push) begin
         slot_ff[wr_ptr_ff] <= emit.data;
      end
   end

endmodule

### rtl/core/text_to_unsigned_parser.sv
// Top level of the streaming text-to-unsigned parser.
// Depends on ttup_pkg, ttup_front, ttup_back and ttup_rsp_queue.
//
// Usage:
//   req_ channel: one character per beat (req_data), pushed while req_full is low.
//   first_char marks the start of a string; unmarked characters outside a string drop.
//   rsp_ channel: one beat per finished number, on the stop character (NUL, non-digit
//   or digit not below the radix); hold a result until rsp_pop while rsp_empty is low.
//   csr_ port: csr_write_data sets the radix (0 = auto hex/decimal); write only when idle.
// Throughput: one character per cycle while the result queue has room; the back end's
//   multiply-add is combinational. Only stop characters, and first characters with a
//   radix above 36, produce beats. Path: character queue, back end, result queue.
// Reset: radix returns to 10, both queues empty, parser idle.
// Stall: with the two-entry result queue full the back end holds, the four-entry
//   character queue fills, and req_full rises.
module text_to_unsigned_parser #(
   parameter int VALUE_WIDTH = ttup_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  ttup_pkg::ttup_req_type          req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output ttup_pkg::ttup_rsp_type          rsp_data,
   input  logic                            csr_write_enable,
   input  logic [ttup_pkg::BASE_WIDTH-1:0] csr_write_data
);

   logic                    mid_valid;
   logic                    mid_take;
   ttup_pkg::ttup_item_type mid_item;
   logic                    rsp_q_full;
   ttup_pkg::ttup_emit_type emit;

   ttup_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mid_valid        (mid_valid),
      .mid_item         (mid_item),
      .mid_take         (mid_take)
   );

   ttup_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mid_valid  (mid_valid),
      .mid_item   (mid_item),
      .mid_take   (mid_take),
      .rsp_q_full (rsp_q_full),
      .emit       (emit)
   );

   ttup_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .rsp_q_full (rsp_q_full),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      emit.push |-> !rsp_q_full)
      else $error("result pushed into a full result queue");

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      mid_take |-> mid_valid)
      else $error("back end took from an empty character queue");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(emit.push))
      else $error("result appeared without a push from the back end");
`endif

endmodule
